[design/epsilon_greedy_arm_selector_defines.svh]
// Assertion macros shared by the arm selector modules.
// No dependencies; included by each file that carries assertions.
`ifndef EPSILON_GREEDY_ARM_SELECTOR_DEFINES_SVH
`define EPSILON_GREEDY_ARM_SELECTOR_DEFINES_SVH

// Same-cycle implication, disabled while reset is held
`define EGAS_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is held
`define EGAS_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/egas_pkg.sv]
// Shared constants, codes and types for the epsilon-greedy arm selector.
// No dependencies.
package egas_pkg;

    localparam int MAX_ARMS  = 16;
    localparam int ARM_W     = 4;
    localparam int NARM_W    = 5;
    localparam int CNT_W     = 24;
    localparam int VAL_W     = 32;
    localparam int FRAC_W    = 16;
    localparam int DIV_W     = VAL_W + 1;
    localparam int DIV_STEPS = DIV_W;
    localparam int DIV_CNT_W = 6;

    localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

    // action codes
    localparam logic [1:0] ACT_SELECT = 2'd0;
    localparam logic [1:0] ACT_UPDATE = 2'd1;
    localparam logic [1:0] ACT_CLEAR  = 2'd2;

    // configuration register indexes
    localparam logic REG_EXPLORE = 1'b0;
    localparam logic REG_ARMS    = 1'b1;

    // one arm's statistics as held in the table
    typedef struct packed {
        logic [CNT_W-1:0]        count;
        logic signed [VAL_W-1:0] value;
    } t_entry;

endpackage

[design/egas_table.sv]
// Arm statistics table: one write port, one registered read port.
// Per-entry valid bits let a clear empty every entry at once. Depends on egas_pkg.
module egas_table (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_clear,
    input  logic                     i_rd_en,
    input  logic [egas_pkg::ARM_W-1:0] i_rd_addr,
    output egas_pkg::t_entry         o_rd_data,
    input  logic                     i_wr_en,
    input  logic [egas_pkg::ARM_W-1:0] i_wr_addr,
    input  egas_pkg::t_entry         i_wr_data
);
    import egas_pkg::*;

    t_entry              r_mem [MAX_ARMS];
    logic [MAX_ARMS-1:0] r_valid;
    t_entry              r_rd_data;
    logic                r_rd_valid;

    // storage array, no reset
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits: cleared by reset or clear, set on write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_clear) begin
                r_valid <= '0;
            end else if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // an entry never written since clear reads as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

[design/egas_div.sv]
// Serial restoring divider: signed 33-bit dividend by unsigned 24-bit divisor,
// one quotient bit per cycle, truncation toward zero. Depends on egas_pkg.
module egas_div (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic signed [egas_pkg::DIV_W-1:0] i_dividend,
    input  logic [egas_pkg::CNT_W-1:0]     i_divisor,
    output logic                           o_done,
    output logic signed [egas_pkg::DIV_W-1:0] o_quot,
    output logic [egas_pkg::CNT_W-1:0]     o_rem
);
    import egas_pkg::*;

    `include "epsilon_greedy_arm_selector_defines.svh"

    logic                 r_busy;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic                 r_neg;
    logic [DIV_W-1:0]     r_mag;
    logic [CNT_W-1:0]     r_rem;
    logic [CNT_W-1:0]     r_div;
    logic [CNT_W:0]       w_shift;
    logic [CNT_W:0]       w_sub;
    logic                 w_ge;

    // one restoring step
    assign w_shift = {r_rem, r_mag[DIV_W-1]};
    assign w_ge    = (w_shift >= {1'b0, r_div});
    assign w_sub   = w_shift - {1'b0, r_div};

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= DIV_CNT_W'(DIV_STEPS - 1);
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    // datapath: magnitude shifts out, quotient bits shift in
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_neg <= i_dividend[DIV_W-1];
            r_mag <= i_dividend[DIV_W-1] ? DIV_W'(-i_dividend) : DIV_W'(i_dividend);
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_mag <= {r_mag[DIV_W-2:0], w_ge};
            r_rem <= w_ge ? w_sub[CNT_W-1:0] : w_shift[CNT_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_mag) : $signed(r_mag);
    assign o_rem  = r_rem;

    `EGAS_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, i_start, !r_busy, "divider restarted while busy")
    `EGAS_ASSERT_NXT(a_done_pulse, i_clk, i_rst_n, r_done, !r_done && !r_busy, "done not a single pulse")

endmodule

[design/epsilon_greedy_arm_selector.sv]
// Path from accepted word to result valid (n = arms in use, one table read a cycle):
//   exploit select, clear, unused action, rejected update: argmax walk over n arms;
//   explore select: 33-step serial modulo, then walk;
//   update: read, 33-step serial divide, write back, walk.
// One word at a time: the next is taken the cycle after the result loads.
// Synchronous active-low reset: counts and means read as zero, epsilon 6554, 16 arms.
module epsilon_greedy_arm_selector (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [15:0] i_cfg_data,
    // input stream
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    // tdata: random_fraction[15:0], random_arm[31:16], target_arm[35:32],
    //        reward[67:36], zero pad[71:68]
    input  logic [71:0] i_s_tdata,
    // tuser: action[1:0]
    input  logic [1:0]  i_s_tuser,
    // output stream
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    // tdata: selected_arm[3:0], explored[4], best_arm[8:5], status[9], zero pad[15:10]
    output logic [15:0] o_m_tdata
);
    import egas_pkg::*;

    `include "epsilon_greedy_arm_selector_defines.svh"

    localparam logic [2:0] S_IDLE    = 3'd0;
    localparam logic [2:0] S_UPD_RD  = 3'd1;
    localparam logic [2:0] S_UPD_DIV = 3'd2;
    localparam logic [2:0] S_MOD     = 3'd3;
    localparam logic [2:0] S_SCAN    = 3'd4;
    localparam logic [2:0] S_OUT     = 3'd5;

    logic [2:0]        r_state, n_state;
    logic [FRAC_W-1:0] r_eps;
    logic [NARM_W-1:0] r_arms;
    logic [NARM_W-1:0] w_n;

    // input word fields
    logic [1:0]        w_action;
    logic [FRAC_W-1:0] w_frac;
    logic [15:0]       w_rarm;
    logic [ARM_W-1:0]  w_arm;
    logic [VAL_W-1:0]  w_reward;
    logic              w_accept;
    logic              w_exploit;
    logic              w_bad_arm;

    // per-word registers
    logic [ARM_W-1:0]        r_arm;
    logic [VAL_W-1:0]        r_reward;
    logic [ARM_W-1:0]        r_sel;
    logic                    r_expl;
    logic                    r_status;
    logic                    r_use_best;
    logic [CNT_W-1:0]        r_count;
    logic signed [VAL_W-1:0] r_value;

    // table access
    t_entry           w_rd_data;
    logic             w_rd_en;
    logic [ARM_W-1:0] w_rd_addr;
    logic             w_wr_en;
    t_entry           w_wr_data;
    logic             w_clear;
    logic [CNT_W-1:0] w_cnt_new;
    logic signed [DIV_W-1:0] w_diff;

    // divider
    logic                    w_div_start;
    logic signed [DIV_W-1:0] w_div_dividend;
    logic [CNT_W-1:0]        w_div_divisor;
    logic                    w_div_done;
    logic signed [DIV_W-1:0] w_div_quot;
    logic [CNT_W-1:0]        w_div_rem;

    // argmax walk
    logic [NARM_W-1:0]       r_issue;
    logic                    r_cmp_vld;
    logic [ARM_W-1:0]        r_cmp_idx;
    logic [ARM_W-1:0]        r_best;
    logic signed [VAL_W-1:0] r_best_val;
    logic                    w_scan_issue;

    // output register
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic        w_out_load;

    assign w_action = i_s_tuser;
    assign w_frac   = i_s_tdata[15:0];
    assign w_rarm   = i_s_tdata[31:16];
    assign w_arm    = i_s_tdata[35:32];
    assign w_reward = i_s_tdata[67:36];

    // arm count clamped to 1..MAX_ARMS
    always_comb begin
        if (r_arms == '0) begin
            w_n = NARM_W'(1);
        end else if (r_arms > NARM_W'(MAX_ARMS)) begin
            w_n = NARM_W'(MAX_ARMS);
        end else begin
            w_n = r_arms;
        end
    end

    assign o_s_tready = (r_state == S_IDLE);
    assign w_accept   = i_s_tvalid && o_s_tready;
    assign w_exploit  = (w_frac > r_eps);
    assign w_bad_arm  = ({1'b0, w_arm} >= w_n);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eps  <= FRAC_W'(6554);
            r_arms <= NARM_W'(MAX_ARMS);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_EXPLORE: r_eps  <= i_cfg_data;
                REG_ARMS:    r_arms <= i_cfg_data[NARM_W-1:0];
                default:     r_eps  <= r_eps;
            endcase
        end
    end

    // update read-modify: saturating count and exact 33-bit difference
    assign w_cnt_new = (w_rd_data.count == COUNT_MAX) ? w_rd_data.count
                                                      : w_rd_data.count + 1'b1;
    assign w_diff    = $signed({r_reward[VAL_W-1], r_reward})
                     - $signed({w_rd_data.value[VAL_W-1], w_rd_data.value});

    // divider is shared by the update step and the explore modulo
    assign w_div_start    = (w_accept && (w_action == ACT_SELECT) && !w_exploit)
                          || (r_state == S_UPD_RD);
    assign w_div_dividend = (r_state == S_UPD_RD) ? w_diff
                                                  : $signed({17'd0, w_rarm});
    assign w_div_divisor  = (r_state == S_UPD_RD) ? w_cnt_new
                                                  : {{(CNT_W-NARM_W){1'b0}}, w_n};

    egas_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dividend),
        .i_divisor  (w_div_divisor),
        .o_done     (w_div_done),
        .o_quot     (w_div_quot),
        .o_rem      (w_div_rem)
    );

    // table port control
    assign w_scan_issue = (r_state == S_SCAN) && (r_issue < w_n);
    assign w_rd_en      = (w_accept && (w_action == ACT_UPDATE) && !w_bad_arm)
                        || w_scan_issue;
    assign w_rd_addr    = (r_state == S_SCAN) ? r_issue[ARM_W-1:0] : w_arm;
    assign w_clear      = w_accept && (w_action == ACT_CLEAR);
    assign w_wr_en      = (r_state == S_UPD_DIV) && w_div_done;
    assign w_wr_data.count = r_count;
    assign w_wr_data.value = r_value + w_div_quot[VAL_W-1:0];

    egas_table u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_clear   (w_clear),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (r_arm),
        .i_wr_data (w_wr_data)
    );

    // sequencer next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (w_action)
                        ACT_SELECT: n_state = w_exploit ? S_SCAN : S_MOD;
                        ACT_UPDATE: n_state = w_bad_arm ? S_SCAN : S_UPD_RD;
                        default:    n_state = S_SCAN;
                    endcase
                end
            end
            S_UPD_RD:  n_state = S_UPD_DIV;
            S_UPD_DIV: if (w_div_done) n_state = S_SCAN;
            S_MOD:     if (w_div_done) n_state = S_SCAN;
            S_SCAN:    if (!w_scan_issue && !r_cmp_vld) n_state = S_OUT;
            S_OUT:     if (w_out_load) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // per-word payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_arm      <= w_arm;
            r_reward   <= w_reward;
            r_sel      <= '0;
            r_expl     <= (w_action == ACT_SELECT) && !w_exploit;
            r_use_best <= (w_action == ACT_SELECT) && w_exploit;
            r_status   <= (w_action == ACT_UPDATE) && w_bad_arm;
        end
        if (r_state == S_UPD_RD) begin
            r_count <= w_cnt_new;
            r_value <= w_rd_data.value;
        end
        if ((r_state == S_MOD) && w_div_done) begin
            r_sel <= w_div_rem[ARM_W-1:0];
        end
    end

    // argmax walk: issue one read a cycle, compare as data returns
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
        end else if (r_state == S_SCAN) begin
            r_cmp_vld <= w_scan_issue;
            if (w_scan_issue) begin
                r_issue <= r_issue + 1'b1;
            end
        end else begin
            r_issue   <= '0;
            r_cmp_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_scan_issue) begin
            r_cmp_idx <= r_issue[ARM_W-1:0];
        end
        if (r_cmp_vld) begin
            if ((r_cmp_idx == '0) || (w_rd_data.value > r_best_val)) begin
                r_best     <= r_cmp_idx;
                r_best_val <= w_rd_data.value;
            end
        end
    end

    // output register
    assign w_out_load = (r_state == S_OUT) && (!r_out_valid || i_m_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            r_out_data <= {6'd0, r_status, r_best, r_expl,
                           (r_use_best ? r_best : r_sel)};
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    `EGAS_ASSERT_IMP(a_cmp_in_range, i_clk, i_rst_n, r_cmp_vld,
        ({1'b0, r_cmp_idx} < w_n), "walk compared an arm outside those in use")
    `EGAS_ASSERT_NXT(a_busy_after_accept, i_clk, i_rst_n, w_accept,
        !o_s_tready, "new word taken before the current one finished")
    `EGAS_ASSERT_IMP(a_done_expected, i_clk, i_rst_n, w_div_done,
        ((r_state == S_MOD) || (r_state == S_UPD_DIV)), "divider finished out of turn")

endmodule
